FILE: rtl/pce_pkg.sv
// Shared types and constants for the prefix-code byte encoder.
`timescale 1ns / 1ps

package pce_pkg;

  // Bits in one packed output byte.
  localparam int BYTE_W = 8;

  // Largest number of bytes one item can put out, for the widest supported code.
  localparam int BATCH_MAX = 4;
  localparam int CNT_W     = 3;

  // Request kinds carried by req_type.
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_DATA = 2'd1,
    REQ_END  = 2'd2
  } req_t;

  // Group of result bytes produced by one item, handed from packer to serializer.
  typedef struct packed {
    logic [CNT_W-1:0]                  count;
    logic                              trail;
    logic [BATCH_MAX-1:0][BYTE_W-1:0]  bytes;
  } batch_t;

endpackage

FILE: rtl/pce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pce_packer.sv
// Bit packer: joins a code word to the pending bits and forms the output bytes.
`timescale 1ns / 1ps

module pce_packer #(
  parameter int CW = 32,
  parameter int LW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [1:0]          kind,
  input  logic                in_range,
  input  logic [CW-1:0]       code,
  input  logic [LW-1:0]       len,
  output pce_pkg::batch_t     batch
);

  import pce_pkg::*;

  localparam int W    = 7 + CW;
  localparam int TW   = $clog2(W + 1);
  localparam int MAXB = W / BYTE_W;

  logic [6:0]    pending_bits, pending_bits_next;
  logic [2:0]    pending_count, pending_count_next;
  logic          has_bits, has_bits_next;

  logic [CW-1:0] code_mask;
  logic [W-1:0]  acc;
  logic [W-1:0]  left;
  logic [W+63:0] left_ext;
  logic [TW-1:0] total;
  logic [6:0]    rem_mask;
  logic [2:0]    pad;

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      code_mask[i] = (i < int'(len));
    end
    acc      = (W'(pending_bits) << len) | W'(code & code_mask);
    total    = TW'(pending_count) + TW'(len);
    left     = acc << (TW'(W) - total);
    left_ext = {left, 64'b0};
    for (int i = 0; i < 7; i++) begin
      rem_mask[i] = (i < int'(total[2:0]));
    end
    pad = 3'(4'd8 - {1'b0, pending_count});
  end

  always_comb begin
    batch              = '0;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    has_bits_next      = has_bits;
    case (kind)
      REQ_DATA: begin
        if (in_range && (len != '0)) begin
          for (int i = 0; i < BATCH_MAX; i++) begin
            if (i < MAXB) begin
              batch.bytes[i] = left_ext[W+63-BYTE_W*i -: BYTE_W];
            end
          end
          batch.count        = CNT_W'(total >> 3);
          pending_bits_next  = acc[6:0] & rem_mask;
          pending_count_next = total[2:0];
          has_bits_next      = 1'b1;
        end
      end
      REQ_END: begin
        batch.trail = 1'b1;
        if (pending_count != '0) begin
          batch.bytes[0] = 8'({1'b0, pending_bits} << pad);
          batch.bytes[1] = {5'b0, pad};
          batch.count    = CNT_W'(2);
        end else if (!has_bits) begin
          batch.bytes[0] = '0;
          batch.bytes[1] = 8'(BYTE_W);
          batch.count    = CNT_W'(2);
        end else begin
          batch.bytes[0] = '0;
          batch.count    = CNT_W'(1);
        end
        pending_bits_next  = '0;
        pending_count_next = '0;
        has_bits_next      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      has_bits      <= 1'b0;
    end else if (take) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      has_bits      <= has_bits_next;
    end
  end

endmodule

FILE: rtl/pce_serializer.sv
// Output shift register that sends a batch of bytes one per handshake.
`timescale 1ns / 1ps

module pce_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pce_pkg::batch_t   batch,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              is_trailer,
  output logic              last,
  output logic              free
);

  import pce_pkg::*;

  logic [BATCH_MAX-1:0][BYTE_W-1:0] bytes;
  logic [CNT_W-1:0]                 remaining;
  logic                             trail;
  logic                             sent;

  assign out_valid  = (remaining != '0);
  assign sent       = out_valid && !out_stall;
  assign out_byte   = bytes[0];
  assign is_trailer = trail && (remaining == CNT_W'(1));
  assign last       = is_trailer;
  assign free       = (remaining == '0) || ((remaining == CNT_W'(1)) && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      trail     <= 1'b0;
    end else if (load) begin
      remaining <= batch.count;
      trail     <= batch.trail;
    end else if (sent) begin
      remaining <= remaining - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= batch.bytes;
    end else if (sent) begin
      for (int i = 0; i < BATCH_MAX - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
      bytes[BATCH_MAX-1] <= '0;
    end
  end

endmodule

FILE: rtl/prefix_code_byte_encoder_unit.sv
// Top level of the prefix-code byte encoder: table, bit packer and byte output.
`timescale 1ns / 1ps

// Prefix-code byte encoder. A load item (req_type 0) stores the code word and
// length for one symbol in a table RAM; a data item (req_type 1) looks up the
// code of its symbol and appends it, most significant code bit first, to a bit
// accumulator, and every full byte leaves on the output channel; an end item
// (req_type 2) zero-pads any partial byte, sends it, and then sends a trailer
// byte with the pad count (is_trailer and last high). An empty message gives a
// zero byte and a trailer of 8. Encoding a symbol whose entry was never loaded
// gives undefined bytes. A load item puts out no byte, an end item one or two,
// and a data item as many bytes as it completes, up to four with 32-bit codes.
// The input is stalled only while stage 1 holds an item that the byte-wide
// output shift register cannot yet take. The registered table read and the
// output register lie between the input handshake and the first output byte.
module prefix_code_byte_encoder_unit #(
  parameter int MAX_CODE_BITS = 32,
  parameter int SYMBOL_COUNT  = 256
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  symbol,
  input  logic [31:0] code_value,
  input  logic [5:0]  code_length,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_trailer,
  output logic        last
);

  import pce_pkg::*;

  // Codes are never longer than the 32-bit code_value field.
  localparam int LEN_MAX = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
  localparam int CW      = LEN_MAX;
  localparam int LW      = $clog2(LEN_MAX + 1);
  localparam int AW      = $clog2(SYMBOL_COUNT);

  logic          in_accept;
  logic          sym_in_range;
  logic [LW-1:0] load_len;
  logic          table_we;

  logic          s1_valid;
  logic [1:0]    s1_kind;
  logic          s1_in_range;
  logic          advance;
  logic          ser_free;

  logic [CW+LW-1:0] table_rdata;
  batch_t           batch;

  assign in_accept    = in_valid && !in_stall;
  assign sym_in_range = ({1'b0, symbol} < 9'(SYMBOL_COUNT));

  // A length beyond the supported maximum is clamped on the way into the table.
  assign load_len = ({1'b0, code_length} > 7'(LEN_MAX)) ? LW'(LEN_MAX) : LW'(code_length);
  assign table_we = in_accept && (req_t'(req_type) == REQ_LOAD) && sym_in_range;

  // The table is written at the load's handshake, so a data item accepted in
  // the very next cycle already reads the new entry.
  pce_ram #(
    .WIDTH (CW + LW),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (symbol[AW-1:0]),
    .wdata ({code_value[CW-1:0], load_len}),
    .re    (in_accept),
    .raddr (symbol[AW-1:0]),
    .rdata (table_rdata)
  );

  // Stage 1 holds the item while its table entry is read; it moves into the
  // packer once the output register can take the new batch of bytes.
  assign advance  = s1_valid && ser_free;
  assign in_stall = s1_valid && !ser_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind     <= req_type;
      s1_in_range <= sym_in_range;
    end
  end

  pce_packer #(
    .CW (CW),
    .LW (LW)
  ) u_packer (
    .clk      (clk),
    .rst      (rst),
    .take     (advance),
    .kind     (s1_kind),
    .in_range (s1_in_range),
    .code     (table_rdata[CW+LW-1:LW]),
    .len      (table_rdata[LW-1:0]),
    .batch    (batch)
  );

  pce_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .batch      (batch),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .is_trailer (is_trailer),
    .last       (last),
    .free       (ser_free)
  );

endmodule
